/* design/sorted_rank_query_two_level_core_defines.svh */
`ifndef SORTED_RANK_QUERY_TWO_LEVEL_CORE_DEFINES_SVH
`define SORTED_RANK_QUERY_TWO_LEVEL_CORE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define SRQ2L_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define SRQ2L_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/srq2l_pkg.sv */
`default_nettype none

package srq2l_pkg;

  localparam int MAX_ELEMENTS    = 4096;
  localparam int MAX_BLOCK_SLOTS = 64;

  localparam int ELEM_AW = $clog2(MAX_ELEMENTS);
  localparam int SLOT_AW = $clog2(MAX_BLOCK_SLOTS);

  // field widths
  localparam int OP_W    = 2;
  localparam int INDEX_W = 12;
  localparam int VALUE_W = 32;
  localparam int FIRST_W = 12;
  localparam int LEN_W   = 13;
  localparam int CNT_W   = 13;
  localparam int NB_W    = 7;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [OP_W-1:0] OP_LOAD_ELEM = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_DESC = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY     = 2'd2;

  // register select is paddr[2]
  localparam logic REG_ELEMENT_COUNT = 1'b0;
  localparam logic REG_BLOCK_COUNT   = 1'b1;

  typedef struct packed {
    logic [VALUE_W-1:0] limit;
    logic [FIRST_W-1:0] first;
    logic [LEN_W-1:0]   length;
    logic [CNT_W-1:0]   before_cnt;
  } desc_t;

endpackage

`default_nettype wire

/* design/srq2l_if.sv */
`default_nettype none

interface srq2l_req_if;
  logic                                valid;
  logic                                ready;
  logic [srq2l_pkg::OP_W-1:0]          operation;
  logic [srq2l_pkg::INDEX_W-1:0]       index;
  logic [srq2l_pkg::VALUE_W-1:0]       value;
  logic [srq2l_pkg::FIRST_W-1:0]       block_first;
  logic [srq2l_pkg::LEN_W-1:0]         block_length;
  logic [srq2l_pkg::CNT_W-1:0]         block_before;

  modport source (
    output valid, operation, index, value, block_first, block_length, block_before,
    input  ready
  );
  modport sink (
    input  valid, operation, index, value, block_first, block_length, block_before,
    output ready
  );
endinterface

interface srq2l_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [srq2l_pkg::CNT_W-1:0] count;

  modport source (output valid, count, input ready);
  modport sink (input valid, count, output ready);
endinterface

`default_nettype wire

/* design/srq2l_ram.sv */
`default_nettype none

module srq2l_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* design/sorted_rank_query_two_level_core.sv */
// Rank query over a sorted element RAM (4096 x 32) indexed by up to 64 block
// descriptors. Load requests write one element or one descriptor in the cycle
// they are accepted and give no result; descriptor slots past 63 are dropped,
// and a load leaves the block ready for the next request. A query request
// returns how many of the first element_count elements (at most 4096) are
// strictly below the key: it checks the first and last element, binary-searches
// the descriptors on their limits, reads the chosen descriptor, then
// binary-searches inside that block. Each first, last and search step is one
// registered RAM read followed by one pass through the shared 32-bit comparator.
// The descriptor search takes at most floor(log2(block_count)) + 1 steps, with
// block_count taken as 1 to 64, and the in-block search at most
// floor(log2(clipped block length)) + 1 (0 for an empty range). The result is
// raised in the same cycle in which the next request can be taken; a finished
// query waits further only while an earlier result is still unread. Requests
// are not taken while a query runs. Registers: element_count at 0x0,
// block_count at 0x4, both write/read over the APB port; write them only while
// idle.
`default_nettype none

`include "sorted_rank_query_two_level_core_defines.svh"

module sorted_rank_query_two_level_core (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [srq2l_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [srq2l_pkg::PDATA_W-1:0]   pwdata,
  output logic      [srq2l_pkg::PDATA_W-1:0]   prdata,
  output logic                                 pready,
  srq2l_req_if.sink                            req,
  srq2l_rsp_if.source                          rsp
);

  localparam int CW = srq2l_pkg::CNT_W;
  localparam int NW = srq2l_pkg::NB_W;

  typedef enum logic [3:0] {
    S_IDLE, S_FIRST, S_FIRST_CHK, S_LAST, S_LAST_CHK, S_BLK, S_BLK_CHK,
    S_DESC, S_DESC_CHK, S_ELEM, S_ELEM_CHK, S_DONE
  } state_t;

  state_t state;

  logic [CW-1:0] element_count;
  logic [NW-1:0] block_count;
  logic [CW-1:0] n_eff;
  logic [CW-1:0] n_m1;
  logic [NW-1:0] nb_eff;

  logic [srq2l_pkg::VALUE_W-1:0] key;
  logic [CW-1:0] lo;
  logic [CW-1:0] hi;
  logic [CW-1:0] start;
  logic [CW-1:0] blk_before;
  logic [NW-1:0] ans;
  logic [CW-1:0] res;
  logic [CW-1:0] rsp_count;
  logic          rsp_valid;

  logic          req_fire;
  logic          cfg_wr;
  logic [CW:0]   mid_sum;
  logic [CW-1:0] mid;

  logic                              elem_we;
  logic [srq2l_pkg::ELEM_AW-1:0]     elem_raddr;
  logic [srq2l_pkg::VALUE_W-1:0]     elem_rdata;
  logic                              desc_we;
  logic [srq2l_pkg::SLOT_AW-1:0]     desc_raddr;
  logic [$bits(srq2l_pkg::desc_t)-1:0] desc_wdata;
  logic [$bits(srq2l_pkg::desc_t)-1:0] desc_rdata;
  srq2l_pkg::desc_t                  desc_wr;
  srq2l_pkg::desc_t                  desc_rd;

  logic [srq2l_pkg::VALUE_W-1:0] cmp_word;
  logic          word_lt_key;
  logic [CW:0]   end_sum;
  logic [CW-1:0] hi_clip;
  logic [CW-1:0] lo_clip;
  logic [CW:0]   total_sum;
  logic [CW-1:0] total;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      element_count <= '0;
      block_count   <= NW'(1);
    end else if (cfg_wr) begin
      case (paddr[2])
        srq2l_pkg::REG_ELEMENT_COUNT: element_count <= pwdata[CW-1:0];
        srq2l_pkg::REG_BLOCK_COUNT:   block_count   <= pwdata[NW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      srq2l_pkg::REG_ELEMENT_COUNT: prdata = srq2l_pkg::PDATA_W'(element_count);
      srq2l_pkg::REG_BLOCK_COUNT:   prdata = srq2l_pkg::PDATA_W'(block_count);
      default:                      prdata = '0;
    endcase
  end

  assign n_eff = (element_count > CW'(srq2l_pkg::MAX_ELEMENTS)) ?
                 CW'(srq2l_pkg::MAX_ELEMENTS) : element_count;
  assign n_m1  = n_eff - CW'(1);
  assign nb_eff = (block_count == '0) ? NW'(1) :
                  (block_count > NW'(srq2l_pkg::MAX_BLOCK_SLOTS)) ?
                  NW'(srq2l_pkg::MAX_BLOCK_SLOTS) : block_count;

  // request handshake
  assign req.ready = (state == S_IDLE) && !rst;
  assign req_fire  = req.valid && req.ready;

  // memories
  assign elem_we = req_fire && (req.operation == srq2l_pkg::OP_LOAD_ELEM) &&
                   ({1'b0, req.index} < (srq2l_pkg::INDEX_W + 1)'(srq2l_pkg::MAX_ELEMENTS));
  assign desc_we = req_fire && (req.operation == srq2l_pkg::OP_LOAD_DESC) &&
                   ({1'b0, req.index} <
                    (srq2l_pkg::INDEX_W + 1)'(srq2l_pkg::MAX_BLOCK_SLOTS));

  assign desc_wr.limit      = req.value;
  assign desc_wr.first      = req.block_first;
  assign desc_wr.length     = req.block_length;
  assign desc_wr.before_cnt = req.block_before;
  assign desc_wdata = desc_wr;
  assign desc_rd    = srq2l_pkg::desc_t'(desc_rdata);

  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign mid     = mid_sum[CW:1];

  always_comb begin
    case (state)
      S_FIRST: elem_raddr = '0;
      S_LAST:  elem_raddr = n_m1[srq2l_pkg::ELEM_AW-1:0];
      default: elem_raddr = mid[srq2l_pkg::ELEM_AW-1:0];
    endcase
  end

  assign desc_raddr = (state == S_DESC) ? ans[srq2l_pkg::SLOT_AW-1:0] :
                                          mid[srq2l_pkg::SLOT_AW-1:0];

  srq2l_ram #(
    .WIDTH (srq2l_pkg::VALUE_W),
    .DEPTH (srq2l_pkg::MAX_ELEMENTS)
  ) u_elem_ram (
    .clk   (clk),
    .we    (elem_we),
    .waddr (req.index[srq2l_pkg::ELEM_AW-1:0]),
    .wdata (req.value),
    .raddr (elem_raddr),
    .rdata (elem_rdata)
  );

  srq2l_ram #(
    .WIDTH ($bits(srq2l_pkg::desc_t)),
    .DEPTH (srq2l_pkg::MAX_BLOCK_SLOTS)
  ) u_desc_ram (
    .clk   (clk),
    .we    (desc_we),
    .waddr (req.index[srq2l_pkg::SLOT_AW-1:0]),
    .wdata (desc_wdata),
    .raddr (desc_raddr),
    .rdata (desc_rdata)
  );

  // shared comparator: element or block limit against the key
  assign cmp_word    = (state == S_BLK_CHK) ? desc_rd.limit : elem_rdata;
  assign word_lt_key = cmp_word < key;

  // in-block range, clipped to the valid elements
  always_comb begin
    end_sum = (CW + 1)'(desc_rd.first) + (CW + 1)'(desc_rd.length);
    hi_clip = (end_sum > {1'b0, n_eff}) ? n_eff : end_sum[CW-1:0];
    lo_clip = (CW'(desc_rd.first) > hi_clip) ? hi_clip : CW'(desc_rd.first);
    total_sum = (CW + 1)'(blk_before) + (CW + 1)'(lo - start);
    total = (total_sum > {1'b0, n_eff}) ? n_eff : total_sum[CW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      if ((state == S_DONE) && (!rsp_valid || rsp.ready)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_fire && (req.operation == srq2l_pkg::OP_QUERY)) begin
            key <= req.value;
            if (n_eff == '0) begin
              res   <= '0;
              state <= S_DONE;
            end else begin
              state <= S_FIRST;
            end
          end
        end
        S_FIRST: state <= S_FIRST_CHK;
        S_FIRST_CHK: begin
          if (!word_lt_key) begin
            res   <= '0;
            state <= S_DONE;
          end else begin
            state <= S_LAST;
          end
        end
        S_LAST: state <= S_LAST_CHK;
        S_LAST_CHK: begin
          if (word_lt_key) begin
            res   <= n_eff;
            state <= S_DONE;
          end else begin
            lo    <= '0;
            hi    <= CW'(nb_eff);
            ans   <= nb_eff - NW'(1);
            state <= S_BLK;
          end
        end
        S_BLK: state <= (lo < hi) ? S_BLK_CHK : S_DESC;
        S_BLK_CHK: begin
          // first block whose limit reaches the key
          if (!word_lt_key) begin
            ans <= mid[NW-1:0];
            hi  <= mid;
          end else begin
            lo  <= mid + CW'(1);
          end
          state <= S_BLK;
        end
        S_DESC: state <= S_DESC_CHK;
        S_DESC_CHK: begin
          lo         <= lo_clip;
          start      <= lo_clip;
          hi         <= hi_clip;
          blk_before <= desc_rd.before_cnt;
          state      <= S_ELEM;
        end
        S_ELEM: begin
          if (lo < hi) begin
            state <= S_ELEM_CHK;
          end else begin
            res   <= total;
            state <= S_DONE;
          end
        end
        S_ELEM_CHK: begin
          if (word_lt_key) begin
            lo <= mid + CW'(1);
          end else begin
            hi <= mid;
          end
          state <= S_ELEM;
        end
        S_DONE: begin
          // output register free, or emptied at this edge
          if (!rsp_valid || rsp.ready) begin
            rsp_count <= res;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid = rsp_valid;
  assign rsp.count = rsp_count;

  `SRQ2L_ASSERT_IMPL(a_count_bound, clk, rst, rsp_valid, rsp_count <= n_eff,
    "result above element count")
  `SRQ2L_ASSERT_IMPL(a_elem_range, clk, rst, state == S_ELEM,
    (lo <= hi) && (hi <= n_eff), "in-block search range out of order")
  `SRQ2L_ASSERT_IMPL(a_blk_range, clk, rst, state == S_BLK,
    (hi <= CW'(nb_eff)) && (ans < nb_eff), "descriptor search beyond block count")
  `SRQ2L_ASSERT_IMPL(a_rsp_from_done, clk, rst, $rose(rsp_valid),
    $past(state) == S_DONE, "result raised outside completion")
  `SRQ2L_ASSERT_NEXT(a_query_busy, clk, rst,
    req_fire && (req.operation == srq2l_pkg::OP_QUERY), !req.ready,
    "request taken during a query")

endmodule

`default_nettype wire

/* bench/tb_sorted_rank_query_two_level_core.sv */
`default_nettype none

module tb_sorted_rank_query_two_level_core;
  import srq2l_pkg::*;

  localparam logic [OP_W-1:0]    OP_RESERVED        = 2'd3;
  localparam logic [PADDR_W-1:0] ADDR_ELEMENT_COUNT = {REG_ELEMENT_COUNT, 2'b00};
  localparam logic [PADDR_W-1:0] ADDR_BLOCK_COUNT   = {REG_BLOCK_COUNT, 2'b00};
  localparam int QUIET_CYCLES = 64;
  localparam int RANDOM_ITEMS = 400;
  localparam int KEY_TRIES    = 16;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  srq2l_req_if req_ch ();
  srq2l_rsp_if rsp_ch ();

  sorted_rank_query_two_level_core i_dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req     (req_ch),
    .rsp     (rsp_ch)
  );

  // mirror of the block state; slots never loaded stay unknown
  logic [VALUE_W-1:0] elem_mem [MAX_ELEMENTS];
  desc_t              desc_tab [MAX_BLOCK_SLOTS];
  logic [CNT_W-1:0]   cfg_elements;
  logic [NB_W-1:0]    cfg_blocks;

  logic [CNT_W-1:0] rank_q [$];
  logic [CNT_W-1:0] want;

  int send_idle_pct;
  int stall_pct;
  int errors;
  int compared;
  int loads_done;
  int queries_done;
  int settings_done;
  int work_items;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("[sorted_rank_query_two_level_core] ERROR");
    $finish;
  end

  // number of valid elements strictly below key, as the block should see it;
  // known drops when the search would read a slot never loaded
  function automatic logic [CNT_W-1:0] rank_below(input logic [VALUE_W-1:0] key,
                                                  output bit known);
    int n;
    int nb;
    int lo;
    int hi;
    int mid;
    int b;
    int start;
    int total;
    known = 1'b0;
    if ($isunknown(key)) return '0;
    n = (cfg_elements > MAX_ELEMENTS) ? MAX_ELEMENTS : int'(cfg_elements);
    if (n == 0) begin
      known = 1'b1;
      return '0;
    end
    if ($isunknown(elem_mem[0])) return '0;
    if (key <= elem_mem[0]) begin
      known = 1'b1;
      return '0;
    end
    if ($isunknown(elem_mem[n-1])) return '0;
    if (key > elem_mem[n-1]) begin
      known = 1'b1;
      return CNT_W'(n);
    end
    nb = (cfg_blocks == 0) ? 1 : int'(cfg_blocks);
    if (nb > MAX_BLOCK_SLOTS) nb = MAX_BLOCK_SLOTS;
    // first descriptor whose limit reaches the key, else the last one
    b = nb - 1;
    lo = 0;
    hi = nb;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if ($isunknown(desc_tab[mid])) return '0;
      if (desc_tab[mid].limit >= key) begin
        b = mid;
        hi = mid;
      end else begin
        lo = mid + 1;
      end
    end
    if ($isunknown(desc_tab[b])) return '0;
    lo = int'(desc_tab[b].first);
    hi = lo + int'(desc_tab[b].length);
    if (hi > n) hi = n;
    if (lo > hi) lo = hi;
    start = lo;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if ($isunknown(elem_mem[mid])) return '0;
      if (elem_mem[mid] < key) lo = mid + 1;
      else hi = mid;
    end
    total = int'(desc_tab[b].before_cnt) + (lo - start);
    if (total > n) total = n;
    known = 1'b1;
    return CNT_W'(total);
  endfunction

  function automatic logic [VALUE_W-1:0] pick_key();
    int n;
    logic [VALUE_W-1:0] e;
    n = (cfg_elements > MAX_ELEMENTS) ? MAX_ELEMENTS : int'(cfg_elements);
    if (n == 0) return $urandom;
    e = elem_mem[$urandom_range(n - 1)];
    case ($urandom_range(7))
      0: return e;
      1: return e + 1;
      2: return e - 1;
      3: return elem_mem[0];
      4: return elem_mem[n-1] + 1;
      5: return '0;
      6: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic set_idling(int phase);
    case (phase)
      0: begin
        send_idle_pct = 0;
        stall_pct = 0;
      end
      1: begin
        send_idle_pct = 86;
        stall_pct = 0;
      end
      2: begin
        send_idle_pct = 0;
        stall_pct = 86;
      end
      default: begin
        send_idle_pct = 19;
        stall_pct = 19;
      end
    endcase
  endtask

  // one request through the handshake; the mirror is updated on acceptance
  task automatic send_req(logic [OP_W-1:0] op, logic [INDEX_W-1:0] idx,
                          logic [VALUE_W-1:0] val, logic [FIRST_W-1:0] first_idx,
                          logic [LEN_W-1:0] span, logic [CNT_W-1:0] preceding);
    logic [CNT_W-1:0] exp_cnt;
    bit known;
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.operation    <= op;
    req_ch.index        <= idx;
    req_ch.value        <= val;
    req_ch.block_first  <= first_idx;
    req_ch.block_length <= span;
    req_ch.block_before <= preceding;
    @(posedge clk);
    while (req_ch.ready !== 1'b1) @(posedge clk);
    case (op)
      OP_LOAD_ELEM: begin
        elem_mem[idx] = val;
        loads_done++;
        work_items++;
      end
      OP_LOAD_DESC: begin
        if (idx < MAX_BLOCK_SLOTS) begin
          desc_tab[idx].limit      = val;
          desc_tab[idx].first      = first_idx;
          desc_tab[idx].length     = span;
          desc_tab[idx].before_cnt = preceding;
          loads_done++;
          work_items++;
        end
      end
      OP_QUERY: begin
        exp_cnt = rank_below(val, known);
        rank_q = {rank_q, exp_cnt};
        queries_done++;
        work_items++;
      end
      default: ;
    endcase
  endtask

  task automatic load_elem(int slot, logic [VALUE_W-1:0] val);
    send_req(OP_LOAD_ELEM, INDEX_W'(slot), val, FIRST_W'($urandom), LEN_W'($urandom),
             CNT_W'($urandom));
  endtask

  task automatic load_desc(int slot, logic [VALUE_W-1:0] limit, int first_idx, int span,
                           int preceding);
    send_req(OP_LOAD_DESC, INDEX_W'(slot), limit, FIRST_W'(first_idx), LEN_W'(span),
             CNT_W'(preceding));
  endtask

  // a query whose search would read an unloaded slot is not sent
  task automatic send_query(logic [VALUE_W-1:0] key);
    bit known;
    void'(rank_below(key, known));
    if (known)
      send_req(OP_QUERY, INDEX_W'($urandom), key, FIRST_W'($urandom), LEN_W'($urandom),
               CNT_W'($urandom));
  endtask

  task automatic send_random_query();
    logic [VALUE_W-1:0] key;
    bit known;
    repeat (KEY_TRIES) begin
      key = pick_key();
      void'(rank_below(key, known));
      if (known) begin
        send_query(key);
        return;
      end
    end
  endtask

  // requests the block has to drop: unused opcode, descriptor slot off the table
  task automatic send_noise();
    if ($urandom_range(1) == 0)
      send_req(OP_RESERVED, INDEX_W'($urandom), $urandom, FIRST_W'($urandom),
               LEN_W'($urandom), CNT_W'($urandom));
    else
      load_desc(int'($urandom_range(2**INDEX_W - 1, MAX_BLOCK_SLOTS)), $urandom,
                int'($urandom), int'($urandom), int'($urandom));
  endtask

  // pause until every result is in and the last load has certainly landed
  task automatic settle();
    req_ch.valid <= 1'b0;
    while (rank_q.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_counts(int elems, int blocks);
    settle();
    reg_write(ADDR_ELEMENT_COUNT, PDATA_W'(elems));
    cfg_elements = CNT_W'(elems);
    reg_write(ADDR_BLOCK_COUNT, PDATA_W'(blocks));
    cfg_blocks = NB_W'(blocks);
    settings_done++;
  endtask

  // sorted elements in slots 0..n-1 and nb descriptors covering them; a sparse
  // set loads only the head, the middle and the tail of the elements
  task automatic load_set(int n, int nb, bit warp, bit sparse);
    logic [VALUE_W-1:0] vals [];
    int lens [];
    longint unsigned v;
    longint unsigned room;
    int pos;
    desc_t d;
    vals = new[n];
    lens = new[nb];
    v = ($urandom_range(3) == 0) ? 0 : $urandom_range(5000);
    for (int i = 0; i < n; i++) begin
      room = (64'hFFFF_FFFF - v) / (n - i);
      case ($urandom_range(3))
        0: ; // duplicate
        1: v += $urandom_range(50) % (room + 1);
        default: v += room * $urandom_range(1000) / 1000;
      endcase
      vals[i] = v[VALUE_W-1:0];
    end
    for (int b = 0; b < nb; b++) lens[b] = (b < n) ? 1 : 0;
    for (int r = nb; r < n; r++) lens[$urandom_range(nb - 1)]++;

    for (int i = 0; i < n; i++) begin
      if (!sparse || i < 64 || i >= n - 64 || (i >= n / 2 - 32 && i < n / 2 + 32)) begin
        if ($urandom_range(19) == 0) send_noise();
        load_elem(i, vals[i]);
      end
    end
    pos = 0;
    for (int b = 0; b < nb; b++) begin
      if (lens[b] > 0) begin
        d.limit      = vals[pos + lens[b] - 1];
        d.first      = FIRST_W'(pos);
        d.length     = LEN_W'(lens[b]);
        d.before_cnt = CNT_W'(pos);
      end else begin
        // more blocks than elements: the spare ones start past the store
        d.limit      = '1;
        d.first      = FIRST_W'(n + b);
        d.length     = LEN_W'(1);
        d.before_cnt = CNT_W'(n);
      end
      if (warp && $urandom_range(3) == 0) begin
        case ($urandom_range(2))
          0: d.limit = $urandom;
          1: d.length = LEN_W'($urandom_range(2**LEN_W - 1, 1));
          default: d.before_cnt = CNT_W'($urandom);
        endcase
      end
      if ($urandom_range(19) == 0) send_noise();
      load_desc(b, d.limit, int'(d.first), int'(d.length), int'(d.before_cnt));
      pos += lens[b];
    end
  endtask

  task automatic test_empty_store();
    set_idling(2);
    set_counts(0, 2**NB_W - 1);
    send_query('0);
    send_query('1);
    send_query($urandom);
  endtask

  task automatic test_directed();
    logic [VALUE_W-1:0] probe [10] = '{32'h0, 32'h5, 32'h6, 32'h20, 32'h21, 32'h35,
                                       32'h36, 32'h8000_0000, 32'hFFFF_FFFE,
                                       32'hFFFF_FFFF};
    set_idling(0);
    load_elem(0, 32'h5);
    load_elem(1, 32'h20);
    load_elem(2, 32'h20);
    load_elem(3, 32'h35);
    load_elem(4, 32'h8000_0000);
    load_elem(5, 32'hFFFF_FFFE);
    load_desc(0, 32'h20, 0, 3, 0);
    load_desc(1, 32'hFFFF_FFFE, 3, 3, 3);
    send_req(OP_RESERVED, '1, '1, '1, '1, '1);
    load_desc(MAX_BLOCK_SLOTS, '1, -1, -1, -1);
    load_desc(-1, '0, 0, 0, 0);
    set_counts(6, 2);
    foreach (probe[i]) send_query(probe[i]);
    // block count 0 acts as 1; keys above block 0 fall back to it
    set_counts(6, 0);
    send_query(32'h36);
    send_query(32'h21);
    // short store: chosen block starts past it, then an oversized prefix count
    set_counts(3, 2);
    load_desc(0, 32'h10, 0, 3, 0);
    send_query(32'h20);
    send_query(32'h6);
    load_desc(1, 32'hFFFF_FFFE, 3, 3, -1);
    send_query(32'h20);
  endtask

  // full-size store with the head, the middle and the tail of its slots loaded
  task automatic test_full_store();
    set_idling(3);
    load_set(MAX_ELEMENTS, MAX_BLOCK_SLOTS, 1'b0, 1'b1);
    set_counts(2**CNT_W - 1, 2**NB_W - 1);
    repeat (30) send_random_query();
    set_counts(MAX_ELEMENTS, MAX_BLOCK_SLOTS);
    repeat (30) send_random_query();
    set_counts(MAX_ELEMENTS, 1);
    repeat (10) send_random_query();
  endtask

  // register settings may reach past the current set; keys whose search would
  // touch an unloaded slot are skipped
  task automatic test_random_sets();
    int goal;
    int n;
    int nb;
    int elems;
    int blocks;
    int set_no;
    goal = work_items + RANDOM_ITEMS;
    set_no = 0;
    while (work_items < goal) begin
      set_idling(set_no % 4);
      n = ($urandom_range(9) == 0) ? $urandom_range(200, 1) : $urandom_range(40, 1);
      if ($urandom_range(4) == 0) nb = $urandom_range(MAX_BLOCK_SLOTS, 1);
      else nb = $urandom_range((n < 8) ? n : 8, 1);
      load_set(n, nb, $urandom_range(4) == 0, 1'b0);
      repeat ($urandom_range(3, 1)) begin
        case ($urandom_range(9))
          0: elems = $urandom_range(n);
          1: elems = $urandom_range(2**CNT_W - 1);
          default: elems = n;
        endcase
        blocks = ($urandom_range(4) == 0) ? $urandom_range(2**NB_W - 1) : nb;
        set_counts(elems, blocks);
        repeat ($urandom_range(16, 6)) send_random_query();
      end
      set_no++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (rank_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("result with no query pending: count=%0d at %0t", rsp_ch.count, $time);
      end else begin
        want = rank_q.pop_front();
        compared++;
        if (rsp_ch.count !== want) begin
          errors++;
          if (errors <= 10)
            $display("count mismatch: expected %0d, got %0d at %0t", want, rsp_ch.count,
                     $time);
        end
      end
    end
    rsp_ch.ready <= !rst && ($urandom_range(99) >= stall_pct);
  end

  initial begin
    rst                 = 1'b1;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    req_ch.valid        = 1'b0;
    req_ch.operation    = OP_LOAD_ELEM;
    req_ch.index        = '0;
    req_ch.value        = '0;
    req_ch.block_first  = '0;
    req_ch.block_length = '0;
    req_ch.block_before = '0;
    rsp_ch.ready        = 1'b0;
    cfg_elements        = '0;
    cfg_blocks          = NB_W'(1);
    send_idle_pct       = 0;
    stall_pct           = 0;
    errors              = 0;
    compared            = 0;
    loads_done          = 0;
    queries_done        = 0;
    settings_done       = 0;
    work_items          = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_empty_store();
    test_directed();
    test_full_store();
    test_random_sets();
    settle();

    $display("covered %0d loads, %0d rank queries over %0d register settings",
             loads_done, queries_done, settings_done);
    $display("%0d results compared, %0d errors", compared, errors);
    if (errors == 0) begin
      $display("[sorted_rank_query_two_level_core] OK");
    end else begin
      $display("[sorted_rank_query_two_level_core] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
